@@ rtl/cvf_pkg.sv @@
// Shared types, constants and kernel tables for the 3x3 image filter.
package cvf_pkg;

   localparam int MaxWidth   = 4096;
   localparam int MaxHeight  = 4096;
   localparam int ChanW      = 8;
   localparam int NumChan    = 3;
   localparam int ColW       = $clog2(MaxWidth);
   localparam int RowW       = $clog2(MaxHeight) + 1;
   localparam int WidthW     = 13;
   localparam int SumW       = 13;
   localparam int RecipW     = 17;
   localparam int RecipShift = 16;
   localparam int NumTaps    = 9;
   localparam int NumKinds   = 6;

   typedef logic [ChanW-1:0] chan_type;
   typedef chan_type [NumChan-1:0] pix_type;
   typedef logic signed [SumW-1:0] sum_type;

   typedef enum logic [2:0] {
      KIND_SMOOTH,
      KIND_BLUR,
      KIND_SHARPEN,
      KIND_MEAN,
      KIND_EMBOSS,
      KIND_IDENTITY
   } kind_type;

   typedef enum logic [1:0] {
      CSR_FILTER_KIND,
      CSR_IMAGE_WIDTH,
      CSR_COLOR_MODE
   } csr_index_type;

   // taps in window order: top row left to right, then middle, then bottom
   localparam int KernelTaps [0:NumKinds-1][0:NumTaps-1] = '{
      '{ 1,  1,  1,   1,  1,  1,   1,  1,  1},
      '{ 1,  2,  1,   2,  4,  2,   1,  2,  1},
      '{ 0, -2,  0,  -2, 11, -2,   0, -2,  0},
      '{-1, -1, -1,  -1,  9, -1,  -1, -1, -1},
      '{ 0,  1,  0,   0,  0,  0,   0, -1,  0},
      '{ 0,  0,  0,   0,  1,  0,   0,  0,  0}
   };

   // ceil(2^16 / divisor); exact quotient for non-negative sums in range
   localparam logic [RecipW-1:0] KernelRecip [0:NumKinds-1] = '{
      17'd7282, 17'd4096, 17'd21846, 17'd65536, 17'd65536, 17'd65536
   };

   function automatic kind_type to_kind(logic [2:0] raw);
      kind_type k;
      if (raw > 3'(KIND_IDENTITY)) begin
         k = KIND_IDENTITY;
      end else begin
         k = kind_type'(raw);
      end
      return k;
   endfunction

endpackage

@@ rtl/cvf_req_if.sv @@
// Pixel input channel: valid/ready handshake with one pixel per transaction.
interface cvf_req_if;
   logic                 valid;
   logic                 ready;
   logic                 frame_start;
   cvf_pkg::chan_type    chan_red;
   cvf_pkg::chan_type    chan_green;
   cvf_pkg::chan_type    chan_blue;

   modport source (output valid, frame_start, chan_red, chan_green, chan_blue,
                   input ready);
   modport sink   (input valid, frame_start, chan_red, chan_green, chan_blue,
                   output ready);
endinterface

@@ rtl/cvf_rsp_if.sv @@
// Filtered pixel output channel: valid/ready handshake with coordinates.
interface cvf_rsp_if;
   logic                      valid;
   logic                      ready;
   cvf_pkg::chan_type         out_red;
   cvf_pkg::chan_type         out_green;
   cvf_pkg::chan_type         out_blue;
   logic [cvf_pkg::ColW-1:0]  out_row;
   logic [cvf_pkg::ColW-1:0]  out_col;

   modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_row, out_col,
                   output ready);
endinterface

@@ rtl/cvf_chan_sum.sv @@
// Weighted 3x3 kernel sum for one color channel.
module cvf_chan_sum (
   input  cvf_pkg::kind_type                        kind,
   input  cvf_pkg::chan_type [cvf_pkg::NumTaps-1:0] win,
   output cvf_pkg::sum_type                         sum
);

   always_comb begin
      cvf_pkg::sum_type acc;
      cvf_pkg::sum_type weight;
      cvf_pkg::sum_type sample;
      acc = '0;
      for (int i = 0; i < cvf_pkg::NumTaps; i++) begin
         weight = cvf_pkg::SumW'(cvf_pkg::KernelTaps[kind][i]);
         sample = $signed({{(cvf_pkg::SumW - cvf_pkg::ChanW){1'b0}}, win[i]});
         acc = acc + cvf_pkg::SumW'(weight * sample);
      end
      sum = acc;
   end

endmodule

@@ rtl/conv3x3_image_filter.sv @@
// Top level of the 3x3 image filter: line stores, window, kernel pipeline.
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        frame_start, chan_red/green/blue
//   rsp_chan  out   valid/ready        out_red/green/blue, out_row, out_col
//   csr_*     in    csr_we             csr_index, csr_wdata
//
// One pixel per cycle sustained unless rsp_chan stalls; a result's completing pixel passes
// stage 1 (line store read, kernel sums), stage 2 (divide/saturate), then the result register.
// Synchronous active-high reset clears counters, window and valid flags and
// resets the configuration; line stores are not cleared, so no clearing pass follows reset.
// A stalled rsp_chan fills the three stages, then drops req_chan.ready.
module conv3x3_image_filter (
   input  logic                          clock,
   input  logic                          reset,
   cvf_req_if.sink                       req_chan,
   cvf_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [cvf_pkg::WidthW-1:0]    csr_wdata
);

   localparam int ColW   = cvf_pkg::ColW;
   localparam int RowW   = cvf_pkg::RowW;
   localparam int WidthW = cvf_pkg::WidthW;
   localparam int NCh    = cvf_pkg::NumChan;
   localparam int NTap   = cvf_pkg::NumTaps;

   // configuration
   logic [2:0]           filter_kind_ff;
   logic [WidthW-1:0]    image_width_ff;
   logic                 color_mode_ff;
   cvf_pkg::kind_type    kind;
   logic [WidthW-1:0]    eff_width;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_kind_ff <= 3'(cvf_pkg::KIND_IDENTITY);
         image_width_ff <= WidthW'(cvf_pkg::MaxWidth);
         color_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            2'(cvf_pkg::CSR_FILTER_KIND): filter_kind_ff <= csr_wdata[2:0];
            2'(cvf_pkg::CSR_IMAGE_WIDTH): image_width_ff <= csr_wdata;
            2'(cvf_pkg::CSR_COLOR_MODE):  color_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign kind = cvf_pkg::to_kind(filter_kind_ff);

   always_comb begin
      if (image_width_ff < WidthW'(3)) begin
         eff_width = WidthW'(3);
      end else if (image_width_ff > WidthW'(cvf_pkg::MaxWidth)) begin
         eff_width = WidthW'(cvf_pkg::MaxWidth);
      end else begin
         eff_width = image_width_ff;
      end
   end

   // pipeline handshake
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_free, s2_free, s1_free, s1_adv, req_accept, req_ready;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign req_ready  = s1_free;
   assign req_chan.ready = req_ready;
   assign req_accept = req_chan.valid && req_ready;

   // position counters
   logic [ColW-1:0]    col_count_ff, col_count_in, col_base;
   logic [RowW-1:0]    row_count_ff, row_count_in, row_base;
   logic               drop, row_last;
   cvf_pkg::pix_type   req_pix;

   assign col_base = req_chan.frame_start ? '0 : col_count_ff;
   assign row_base = req_chan.frame_start ? '0 : row_count_ff;
   assign drop     = row_base >= RowW'(cvf_pkg::MaxHeight);
   assign row_last = (WidthW'(col_base) + WidthW'(1)) >= eff_width;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_accept && !drop) begin
         col_count_in = row_last ? '0 : col_base + ColW'(1);
         row_count_in = row_last ? row_base + RowW'(1) : row_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   assign req_pix[0] = req_chan.chan_red;
   assign req_pix[1] = color_mode_ff ? req_chan.chan_green : '0;
   assign req_pix[2] = color_mode_ff ? req_chan.chan_blue : '0;

   // stage 1: line store read data, window, kernel sums
   cvf_pkg::pix_type   line_a_mem [0:cvf_pkg::MaxWidth-1];
   cvf_pkg::pix_type   line_b_mem [0:cvf_pkg::MaxWidth-1];
   cvf_pkg::pix_type   line_a_q_ff, line_b_q_ff;
   cvf_pkg::pix_type   s1_pix_ff, s1_fwd_a_ff, s1_fwd_b_ff;
   logic               s1_fwd_ff;
   logic [ColW-1:0]    s1_col_ff;
   logic [ColW-1:0]    s1_row_ff;
   cvf_pkg::pix_type   mid, top;
   cvf_pkg::pix_type   win_ff [0:5];
   cvf_pkg::pix_type   taps [0:NTap-1];
   logic               s1_produce, fwd_hit;

   assign mid = s1_fwd_ff ? s1_fwd_a_ff : line_a_q_ff;
   assign top = s1_fwd_ff ? s1_fwd_b_ff : line_b_q_ff;
   // the previous pixel writes the same column at this edge
   assign fwd_hit = s1_adv && (s1_col_ff == col_base);
   assign s1_produce = (s1_row_ff >= ColW'(2)) && (s1_col_ff >= ColW'(2));

   always_ff @(posedge clock) begin
      if (req_accept) begin
         line_a_q_ff <= line_a_mem[col_base];
         line_b_q_ff <= line_b_mem[col_base];
      end
      if (s1_adv) begin
         line_a_mem[s1_col_ff] <= s1_pix_ff;
         line_b_mem[s1_col_ff] <= mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= !drop;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff   <= req_pix;
         s1_col_ff   <= col_base;
         s1_row_ff   <= row_base[ColW-1:0];
         s1_fwd_ff   <= fwd_hit;
         s1_fwd_a_ff <= s1_pix_ff;
         s1_fwd_b_ff <= mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= s1_pix_ff;
      end
   end

   assign taps[0] = win_ff[0];
   assign taps[1] = win_ff[3];
   assign taps[2] = top;
   assign taps[3] = win_ff[1];
   assign taps[4] = win_ff[4];
   assign taps[5] = mid;
   assign taps[6] = win_ff[2];
   assign taps[7] = win_ff[5];
   assign taps[8] = s1_pix_ff;

   cvf_pkg::sum_type   sums [0:NCh-1];

   for (genvar c = 0; c < NCh; c++) begin : g_chan
      cvf_pkg::chan_type [NTap-1:0] chan_win;
      for (genvar t = 0; t < NTap; t++) begin : g_tap
         assign chan_win[t] = taps[t][c];
      end
      cvf_chan_sum u_sum (
         .kind (kind),
         .win  (chan_win),
         .sum  (sums[c])
      );
   end

   // stage 2: divide by reciprocal multiply, saturate
   cvf_pkg::sum_type   s2_sum_ff [0:NCh-1];
   logic [ColW-1:0]    s2_row_ff, s2_col_ff;
   cvf_pkg::chan_type  quot [0:NCh-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_adv && s1_produce;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free && s1_adv) begin
         for (int c = 0; c < NCh; c++) begin
            s2_sum_ff[c] <= sums[c];
         end
         s2_row_ff <= s1_row_ff - ColW'(1);
         s2_col_ff <= s1_col_ff - ColW'(1);
      end
   end

   always_comb begin
      logic [cvf_pkg::SumW+cvf_pkg::RecipW-2:0] prod;
      logic [cvf_pkg::SumW-1:0]                  q;
      for (int c = 0; c < NCh; c++) begin
         prod = (cvf_pkg::SumW + cvf_pkg::RecipW - 1)'(
                   unsigned'(s2_sum_ff[c][cvf_pkg::SumW-2:0]) * cvf_pkg::KernelRecip[kind]);
         q = cvf_pkg::SumW'(prod >> cvf_pkg::RecipShift);
         if (s2_sum_ff[c][cvf_pkg::SumW-1]) begin
            quot[c] = '0;
         end else if (q > cvf_pkg::SumW'(255)) begin
            quot[c] = '1;
         end else begin
            quot[c] = q[cvf_pkg::ChanW-1:0];
         end
      end
   end

   // result register
   cvf_pkg::chan_type  rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [ColW-1:0]    rsp_row_ff, rsp_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s2_valid_ff) begin
         rsp_red_ff   <= quot[0];
         rsp_green_ff <= color_mode_ff ? quot[1] : '0;
         rsp_blue_ff  <= color_mode_ff ? quot[2] : '0;
         rsp_row_ff   <= s2_row_ff;
         rsp_col_ff   <= s2_col_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_red   = rsp_red_ff;
   assign rsp_chan.out_green = rsp_green_ff;
   assign rsp_chan.out_blue  = rsp_blue_ff;
   assign rsp_chan.out_row   = rsp_row_ff;
   assign rsp_chan.out_col   = rsp_col_ff;

`ifndef SYNTHESIS
   a_frame_start_origin: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_chan.frame_start |=>
         s1_valid_ff && (s1_col_ff == '0) && (s1_row_ff == '0))
      else $error("frame start did not restart at the origin");

   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != '0) && (rsp_col_ff != '0))
      else $error("border pixel emitted");

   a_result_reaches_s2: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_produce |=> s2_valid_ff)
      else $error("interior pixel lost between stages");
`endif

endmodule

@@ test/conv3x3_image_filter_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_image_filter: directed table, random frames, scoreboard.
module conv3x3_image_filter_tb;

   localparam int ColW      = cvf_pkg::ColW;
   localparam int WidthW    = cvf_pkg::WidthW;
   localparam int MaxWidth  = cvf_pkg::MaxWidth;
   localparam int MaxHeight = cvf_pkg::MaxHeight;
   localparam int NumTaps   = cvf_pkg::NumTaps;
   localparam int NumKinds  = cvf_pkg::NumKinds;

   localparam int PipeDrain = 6;
   localparam int RandItems = 430;
   localparam int FillWidth = 40;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   localparam int Taps [0:NumKinds-1][0:NumTaps-1] = '{
      '{ 1,  1,  1,   1,  1,  1,   1,  1,  1},
      '{ 1,  2,  1,   2,  4,  2,   1,  2,  1},
      '{ 0, -2,  0,  -2, 11, -2,   0, -2,  0},
      '{-1, -1, -1,  -1,  9, -1,  -1, -1, -1},
      '{ 0,  1,  0,   0,  0,  0,   0, -1,  0},
      '{ 0,  0,  0,   0,  1,  0,   0,  0,  0}
   };
   localparam int Divisor [0:NumKinds-1] = '{9, 16, 3, 1, 1, 1};

   typedef struct packed {
      logic              frame_start;
      cvf_pkg::chan_type red;
      cvf_pkg::chan_type green;
      cvf_pkg::chan_type blue;
   } pixel_item;

   typedef struct packed {
      cvf_pkg::chan_type red;
      cvf_pkg::chan_type green;
      cvf_pkg::chan_type blue;
      logic [ColW-1:0]   row;
      logic [ColW-1:0]   col;
   } filtered_item;

   typedef struct packed {
      logic               is_csr;
      logic [1:0]         idx;
      logic [WidthW-1:0]  wdata;
      pixel_item          pix;
      logic               typed;
      filtered_item       want;
   } dir_step;

   localparam filtered_item NoRes = '0;
   localparam pixel_item Zero  = '{1'b0, 8'd0, 8'd0, 8'd0};
   localparam pixel_item White = '{1'b0, 8'd255, 8'd255, 8'd255};

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [WidthW-1:0]   csr_wdata;

   cvf_req_if req_if();
   cvf_rsp_if rsp_if();

   conv3x3_image_filter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [23:0]         row_above [MaxWidth];
   logic [23:0]         two_above [MaxWidth];
   logic [23:0]         win [6];
   int                  col_pos;
   int                  row_pos;
   logic [2:0]          cfg_kind;
   logic [WidthW-1:0]   cfg_width;
   logic                cfg_rgb;

   filtered_item        expected_q [$];
   int                  err_count;
   bit                  steady;

   dir_step dir_table [$] = '{
      '{1'b1, cvf_pkg::CSR_IMAGE_WIDTH, 13'd2, Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b1, 8'd0, 8'd0, 8'd0}, 1'b0, NoRes},
      '{1'b0, '0, '0, Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, White, 1'b0, NoRes},
      '{1'b0, '0, '0, Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, Zero, 1'b1, '{8'd255, 8'd0, 8'd0, 12'd1, 12'd1}},
      '{1'b1, cvf_pkg::CSR_COLOR_MODE, 13'd1, Zero, 1'b0, NoRes},
      '{1'b1, cvf_pkg::CSR_FILTER_KIND, 13'(cvf_pkg::KIND_MEAN), Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, White, 1'b0, NoRes},
      '{1'b0, '0, '0, White, 1'b0, NoRes},
      '{1'b0, '0, '0, White, 1'b1, '{8'd0, 8'd0, 8'd0, 12'd2, 12'd1}},
      '{1'b1, cvf_pkg::CSR_FILTER_KIND, 13'(cvf_pkg::KIND_SMOOTH), Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, White, 1'b0, NoRes},
      '{1'b0, '0, '0, White, 1'b0, NoRes},
      '{1'b0, '0, '0, White, 1'b0, NoRes},
      '{1'b1, cvf_pkg::CSR_FILTER_KIND, 13'(cvf_pkg::KIND_BLUR), Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd12, 8'd200, 8'd7}, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd255, 8'd0, 8'd128}, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd64, 8'd33, 8'd250}, 1'b0, NoRes},
      '{1'b1, cvf_pkg::CSR_FILTER_KIND, 13'(cvf_pkg::KIND_SHARPEN), Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd0, 8'd255, 8'd17}, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd90, 8'd90, 8'd90}, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd255, 8'd1, 8'd0}, 1'b0, NoRes},
      '{1'b1, cvf_pkg::CSR_FILTER_KIND, 13'(cvf_pkg::KIND_EMBOSS), Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd3, 8'd250, 8'd77}, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd128, 8'd129, 8'd127}, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd0, 8'd0, 8'd255}, 1'b0, NoRes},
      '{1'b1, cvf_pkg::CSR_FILTER_KIND, 13'(KIND_SPARE_HI), Zero, 1'b0, NoRes},
      '{1'b1, CSR_SPARE, 13'h1FFF, Zero, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd17, 8'd34, 8'd51}, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd68, 8'd85, 8'd102}, 1'b0, NoRes},
      '{1'b0, '0, '0, '{1'b0, 8'd119, 8'd136, 8'd153}, 1'b0, NoRes}
   };

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int active_width();
      int w;
      w = int'(cfg_width);
      if (w < 3) w = 3;
      if (w > MaxWidth) w = MaxWidth;
      return w;
   endfunction

   function automatic cvf_pkg::chan_type kernel_out(input logic [23:0] nb [9], input int ch,
                                                    input int k);
      int sum;
      int q;
      sum = 0;
      for (int i = 0; i < NumTaps; i++) begin
         sum += Taps[k][i] * int'(nb[i][ch*8 +: 8]);
      end
      q = sum / Divisor[k];
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return cvf_pkg::chan_type'(q);
   endfunction

   // advances the filter state by one pixel; returns 1 when a filtered pixel is due
   function automatic bit filter_pixel(input pixel_item px, output filtered_item res);
      int          w;
      int          col;
      int          row;
      int          k;
      logic [23:0] cur;
      logic [23:0] top;
      logic [23:0] mid;
      logic [23:0] nb [9];
      bit          hit;
      hit = 1'b0;
      res = '0;
      w = active_width();
      k = (cfg_kind > 3'(cvf_pkg::KIND_IDENTITY)) ? int'(cvf_pkg::KIND_IDENTITY)
                                                   : int'(cfg_kind);
      if (px.frame_start) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (row_pos >= MaxHeight) return 1'b0;
      col = (col_pos >= MaxWidth) ? MaxWidth - 1 : col_pos;
      row = row_pos;
      cur = cfg_rgb ? {px.blue, px.green, px.red} : {16'h0000, px.red};
      top = two_above[col];
      mid = row_above[col];
      if (row >= 2 && col >= 2) begin
         nb = '{win[0], win[3], top, win[1], win[4], mid, win[2], win[5], cur};
         res.red   = kernel_out(nb, 0, k);
         res.green = cfg_rgb ? kernel_out(nb, 1, k) : 8'h00;
         res.blue  = cfg_rgb ? kernel_out(nb, 2, k) : 8'h00;
         res.row   = ColW'(row - 1);
         res.col   = ColW'(col - 1);
         hit = 1'b1;
      end
      two_above[col] = mid;
      row_above[col] = cur;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = cur;
      if (col + 1 >= w) begin
         col_pos = 0;
         row_pos = row + 1;
      end else begin
         col_pos = col + 1;
      end
      return hit;
   endfunction

   // idle cycles before the next transaction: none while steady, else each cycle idles with 38% odds
   function automatic int pick_gap();
      int gap;
      gap = 0;
      if (steady) return 0;
      while ($urandom_range(0, 99) < 38) gap++;
      return gap;
   endfunction

   function automatic cvf_pkg::chan_type rand_chan();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return cvf_pkg::chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [WidthW-1:0] pick_width();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 10) return WidthW'($urandom_range(0, 2));
      if (r < 22) return WidthW'($urandom_range(10, FillWidth));
      return WidthW'($urandom_range(3, 9));
   endfunction

   task automatic report(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      err_count++;
   endtask

   task automatic send_pixel(input pixel_item px, input bit typed, input filtered_item want);
      filtered_item res;
      bit           hit;
      int           gap;
      req_if.valid       <= 1'b1;
      req_if.frame_start <= px.frame_start;
      req_if.chan_red    <= px.red;
      req_if.chan_green  <= px.green;
      req_if.chan_blue   <= px.blue;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      hit = filter_pixel(px, res);
      if (typed) begin
         expected_q.push_back(want);
      end else if (hit) begin
         expected_q.push_back(res);
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [WidthW-1:0] val);
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (PipeDrain) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (cvf_pkg::csr_index_type'(idx))
         cvf_pkg::CSR_FILTER_KIND: cfg_kind  = val[2:0];
         cvf_pkg::CSR_IMAGE_WIDTH: cfg_width = val;
         cvf_pkg::CSR_COLOR_MODE:  cfg_rgb   = val[0];
         default: ;
      endcase
   endtask

   task automatic send_run(input int count, input bit lead_start, input int glitch_pct);
      pixel_item px;
      for (int i = 0; i < count; i++) begin
         px.frame_start = (i == 0 && lead_start) || ($urandom_range(0, 99) < glitch_pct);
         px.red   = rand_chan();
         px.green = rand_chan();
         px.blue  = rand_chan();
         send_pixel(px, 1'b0, NoRes);
      end
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= 38);
      end
   end

   always @(posedge clock) begin : result_check
      filtered_item got;
      filtered_item want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.out_red, rsp_if.out_green, rsp_if.out_blue,
                 rsp_if.out_row, rsp_if.out_col};
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected transaction at row %0d col %0d", got.row, got.col));
         end else begin
            want = expected_q.pop_front();
            if (got.red !== want.red)
               report($sformatf("out_red %0d, expected %0d", got.red, want.red));
            if (got.green !== want.green)
               report($sformatf("out_green %0d, expected %0d", got.green, want.green));
            if (got.blue !== want.blue)
               report($sformatf("out_blue %0d, expected %0d", got.blue, want.blue));
            if (got.row !== want.row)
               report($sformatf("out_row %0d, expected %0d", got.row, want.row));
            if (got.col !== want.col)
               report($sformatf("out_col %0d, expected %0d", got.col, want.col));
         end
      end
   end

   initial begin
      int sent;
      int n;
      int w;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= cvf_pkg::CSR_FILTER_KIND;
      csr_wdata          <= '0;
      req_if.valid       <= 1'b0;
      req_if.frame_start <= 1'b0;
      req_if.chan_red    <= '0;
      req_if.chan_green  <= '0;
      req_if.chan_blue   <= '0;
      err_count = 0;
      steady    = 1'b0;
      foreach (row_above[i]) row_above[i] = '0;
      foreach (two_above[i]) two_above[i] = '0;
      foreach (win[i]) win[i] = '0;
      col_pos   = 0;
      row_pos   = 0;
      cfg_kind  = 3'(cvf_pkg::KIND_IDENTITY);
      cfg_width = WidthW'(MaxWidth);
      cfg_rgb   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         if (dir_table[i].is_csr) begin
            write_csr(dir_table[i].idx, dir_table[i].wdata);
         end else begin
            send_pixel(dir_table[i].pix, dir_table[i].typed, dir_table[i].want);
         end
      end

      // width above the maximum acts as the maximum: row 0 only, nothing emitted
      write_csr(cvf_pkg::CSR_IMAGE_WIDTH, 13'h1FFF);
      send_run(12, 1'b1, 0);

      // widest random width: three rows, the first two filling both line stores; no idling on either side
      write_csr(cvf_pkg::CSR_FILTER_KIND, WidthW'(KIND_SPARE_LO));
      write_csr(cvf_pkg::CSR_IMAGE_WIDTH, WidthW'(FillWidth));
      steady = 1'b1;
      send_run(3 * FillWidth, 1'b1, 0);
      steady = 1'b0;

      sent = 0;
      while (sent < RandItems) begin
         if ($urandom_range(0, 99) < 60)
            write_csr(cvf_pkg::CSR_FILTER_KIND, WidthW'($urandom_range(0, 7)));
         if ($urandom_range(0, 99) < 40)
            write_csr(cvf_pkg::CSR_COLOR_MODE, WidthW'($urandom_range(0, 1)));
         if ($urandom_range(0, 99) < 60)
            write_csr(cvf_pkg::CSR_IMAGE_WIDTH, pick_width());
         w = active_width();
         if ($urandom_range(0, 99) < 85) begin
            n = int'($urandom_range(3, 5)) * w;
            if (n > RandItems - sent) n = RandItems - sent;
            send_run(n, 1'b1, 0);
         end else begin
            // continue the running frame, possibly at a new width, with stray restarts
            n = int'($urandom_range(1, 2 * w));
            if (n > RandItems - sent) n = RandItems - sent;
            send_run(n, 1'b0, 5);
         end
         sent += n;
      end

      // short RGB sharpen frame at the narrowest width
      write_csr(cvf_pkg::CSR_FILTER_KIND, WidthW'(cvf_pkg::KIND_SHARPEN));
      write_csr(cvf_pkg::CSR_COLOR_MODE, 13'd1);
      write_csr(cvf_pkg::CSR_IMAGE_WIDTH, 13'd3);
      send_run(9, 1'b1, 0);

      req_if.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (2 * PipeDrain) @(posedge clock);
      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/cvf_pkg.sv
rtl/cvf_req_if.sv
rtl/cvf_rsp_if.sv
rtl/cvf_chan_sum.sv
rtl/conv3x3_image_filter.sv
test/conv3x3_image_filter_tb.sv
